// ===== hdl/ipv6_address_expander_defines.svh =====
// Assertion macros for the IPv6 address expander.
`ifndef IPV6_ADDRESS_EXPANDER_DEFINES_SVH
`define IPV6_ADDRESS_EXPANDER_DEFINES_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define IAE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define IAE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define IAE_ASSERT_NOW(lbl, ante, cons, msg)
`define IAE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hdl/iae_pkg.sv =====
// Shared types and constants of the IPv6 address expander.
package iae_pkg;

	localparam int GROUPS_DEF = 8;
	localparam int DIGITS_DEF = 4;
	localparam int GROUPS_MAX = 16;
	localparam int CNT_W      = $clog2(GROUPS_MAX + 1);

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_COLON = 8'h3A;

	typedef struct packed {
		logic [7:0] in_char;
		logic       in_last;
	} abbr_word_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_last;
		logic       malformed;
	} full_word_t;

	// Handover from the collector to the emitter.
	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] gcnt;
		logic [CNT_W-1:0] pos;
		logic             err;
	} summary_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EMIT
	} emit_state_t;

endpackage

// ===== hdl/iae_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module iae_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/iae_collect.sv =====
// Character collector: builds groups, writes closed groups to the store.
module iae_collect import iae_pkg::*; #(
	parameter int GROUPS = GROUPS_DEF,
	parameter int DIGITS = DIGITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        abbr_valid,
	output logic                        abbr_stall,
	input  abbr_word_t                  abbr_data,
	input  logic                        done,
	output logic                        ram_we,
	output logic [$clog2(GROUPS)-1:0]   ram_waddr,
	output logic [8*DIGITS-1:0]         ram_wdata,
	output summary_t                    sum
);

	localparam int AW  = $clog2(GROUPS);
	localparam int GCW = $clog2(GROUPS + 1);
	localparam int DCW = $clog2(DIGITS + 1);
	localparam int GW  = 8 * DIGITS;
	localparam logic [GW-1:0] ZERO_GROUP = {DIGITS{CHAR_ZERO}};

	logic           busy_q, start_q;
	logic [GW-1:0]  cur_q;
	logic [DCW-1:0] dcnt_q;
	logic [GCW-1:0] gcnt_q, gpos_q;
	logic           gap_q, prev_q, err_q;

	logic             accept, is_colon, close_req, we;
	logic [GW+7:0]    shifted;
	logic [GW-1:0]    grp, n_cur;
	logic [DCW-1:0]   n_dcnt;
	logic [GCW-1:0]   n_gcnt, n_gpos, fin_pos;
	logic             n_gap, n_err, fin_err;

	assign accept   = abbr_valid && !busy_q;
	assign is_colon = (abbr_data.in_char == CHAR_COLON);
	assign shifted  = {cur_q, abbr_data.in_char};

	always_comb begin
		grp       = cur_q;
		n_dcnt    = dcnt_q;
		n_gcnt    = gcnt_q;
		n_gpos    = gpos_q;
		n_gap     = gap_q;
		n_err     = err_q;
		close_req = 1'b0;
		we        = 1'b0;
		if (is_colon) begin
			if (prev_q) begin
				// second colon in a row: first one marks the gap
				if (gap_q) begin
					n_err = 1'b1;
				end else begin
					n_gap  = 1'b1;
					n_gpos = gcnt_q;
				end
			end else begin
				close_req = 1'b1;
			end
		end else begin
			if (dcnt_q < DCW'(DIGITS)) begin
				grp    = shifted[GW-1:0];
				n_dcnt = dcnt_q + 1'b1;
			end else begin
				n_err = 1'b1;
			end
		end
		if (abbr_data.in_last) begin
			close_req = 1'b1;
		end
		n_cur = grp;
		if (close_req && (n_dcnt != '0)) begin
			if (gcnt_q < GCW'(GROUPS)) begin
				we     = 1'b1;
				n_gcnt = gcnt_q + 1'b1;
			end else begin
				n_err = 1'b1;
			end
			n_cur  = ZERO_GROUP;
			n_dcnt = '0;
		end
		fin_pos = n_gap ? n_gpos : n_gcnt;
		fin_err = n_err || (!n_gap && (n_gcnt != GCW'(GROUPS)));
	end

	assign ram_we    = accept && we;
	assign ram_waddr = gcnt_q[AW-1:0];
	assign ram_wdata = grp;

	assign abbr_stall = busy_q;
	assign sum.start  = start_q;
	assign sum.gcnt   = CNT_W'(gcnt_q);
	assign sum.pos    = CNT_W'(gpos_q);
	assign sum.err    = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			start_q <= 1'b0;
			cur_q   <= ZERO_GROUP;
			dcnt_q  <= '0;
			gcnt_q  <= '0;
			gpos_q  <= '0;
			gap_q   <= 1'b0;
			prev_q  <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (done) begin
				busy_q <= 1'b0;
				gcnt_q <= '0;
				gpos_q <= '0;
				err_q  <= 1'b0;
			end else if (accept) begin
				if (abbr_data.in_last) begin
					// freeze the address summary for the emitter
					busy_q  <= 1'b1;
					start_q <= 1'b1;
					gcnt_q  <= n_gcnt;
					gpos_q  <= fin_pos;
					err_q   <= fin_err;
					cur_q   <= ZERO_GROUP;
					dcnt_q  <= '0;
					gap_q   <= 1'b0;
					prev_q  <= 1'b0;
				end else begin
					cur_q  <= n_cur;
					dcnt_q <= n_dcnt;
					gcnt_q <= n_gcnt;
					gpos_q <= n_gpos;
					gap_q  <= n_gap;
					err_q  <= n_err;
					prev_q <= is_colon;
				end
			end
		end
	end

endmodule

// ===== hdl/iae_emit.sv =====
// Emitter: reads groups back from the store and sends the full text.
module iae_emit import iae_pkg::*; #(
	parameter int GROUPS = GROUPS_DEF,
	parameter int DIGITS = DIGITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  summary_t                    sum,
	output logic                        done,
	output logic                        ram_re,
	output logic [$clog2(GROUPS)-1:0]   ram_raddr,
	input  logic [8*DIGITS-1:0]         ram_rdata,
	output logic                        full_valid,
	input  logic                        full_stall,
	output full_word_t                  full_data
);

	localparam int AW  = $clog2(GROUPS);
	localparam int DCW = $clog2(DIGITS + 1);
	localparam int SW  = $clog2(2 * GROUPS + 1);

	emit_state_t    state_q, state_nxt;
	logic [AW-1:0]  slot_q;
	logic [DCW-1:0] dig_q;
	logic           zero_q;
	logic           out_valid_q;
	full_word_t     out_q;

	logic [SW-1:0] slot_w, gcnt_w, pos_w, miss_w, end_w, shift_w;
	logic          below_gap, in_gap, adv, colon_pos, last_char, load;
	logic [7:0]    digit_char;
	full_word_t    new_word;

	// Slot mapping: below the gap read slot, inside it emit zeros,
	// above it read slot minus the number of missing groups.
	assign slot_w    = SW'(slot_q);
	assign gcnt_w    = SW'(sum.gcnt);
	assign pos_w     = SW'(sum.pos);
	assign miss_w    = SW'(GROUPS) - gcnt_w;
	assign end_w     = pos_w + miss_w;
	assign shift_w   = slot_w + gcnt_w - SW'(GROUPS);
	assign below_gap = (slot_w < pos_w);
	assign in_gap    = !below_gap && (slot_w < end_w);

	assign adv       = !out_valid_q || !full_stall;
	assign colon_pos = (dig_q == DCW'(DIGITS));
	assign last_char = (slot_q == AW'(GROUPS - 1)) && (dig_q == DCW'(DIGITS - 1));

	always_comb begin
		digit_char = CHAR_ZERO;
		for (int d = 0; d < DIGITS; d++) begin
			if (dig_q == DCW'(d)) begin
				digit_char = ram_rdata[8*(DIGITS-1-d) +: 8];
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sum.start) begin
					state_nxt = ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (adv && colon_pos) begin
					state_nxt = ST_FETCH;
				end else if (adv && last_char) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ram_re    = (state_q == ST_FETCH);
		ram_raddr = below_gap ? slot_q : shift_w[AW-1:0];
		load      = (state_q == ST_EMIT) && adv;
		done      = load && last_char;
		new_word.out_char  = colon_pos ? CHAR_COLON : (zero_q ? CHAR_ZERO : digit_char);
		new_word.out_last  = last_char;
		new_word.malformed = sum.err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= '0;
			dig_q       <= '0;
			zero_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			unique case (state_q)
				ST_IDLE: begin
					slot_q <= '0;
					dig_q  <= '0;
				end
				ST_FETCH: begin
					zero_q <= in_gap;
					dig_q  <= '0;
				end
				ST_EMIT: begin
					if (adv) begin
						if (colon_pos) begin
							slot_q <= slot_q + 1'b1;
						end else begin
							dig_q <= dig_q + 1'b1;
						end
					end
				end
				default: begin
					dig_q <= '0;
				end
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!full_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= new_word;
		end
	end

	assign full_valid = out_valid_q;
	assign full_data  = out_q;

endmodule

// ===== hdl/ipv6_address_expander.sv =====
// IPv6 address expander top level: collector, group store and emitter.
// Load: one character word per cycle while abbr_stall is low; the last word triggers emission.
// Start: the last input word raises sum.start; the emitter fetches the first group in ST_FETCH
// and registers the first output word from ST_EMIT. Emission: one store read per group plus
// one cycle per character, paced further by full_stall.
// Reset: arst_n clears all control state; the group store needs no clearing.
`include "ipv6_address_expander_defines.svh"

module ipv6_address_expander import iae_pkg::*; #(
	parameter int GROUPS = GROUPS_DEF,
	parameter int DIGITS = DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       abbr_valid,
	output logic       abbr_stall,
	input  abbr_word_t abbr_data,
	output logic       full_valid,
	input  logic       full_stall,
	output full_word_t full_data
);

	localparam int AW = $clog2(GROUPS);
	localparam int GW = 8 * DIGITS;

	// Store port signals: the collector writes closed groups in order,
	// the emitter reads them back one per output group.
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [GW-1:0] ram_wdata, ram_rdata;

	// Handover of the finished address and release after the last word.
	summary_t sum;
	logic     done;

	iae_collect #(
		.GROUPS (GROUPS),
		.DIGITS (DIGITS)
	) u_collect (
		.clk        (clk),
		.arst_n     (arst_n),
		.abbr_valid (abbr_valid),
		.abbr_stall (abbr_stall),
		.abbr_data  (abbr_data),
		.done       (done),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.sum        (sum)
	);

	// Group store: one entry per group, DIGITS characters wide.
	iae_ram #(
		.WIDTH (GW),
		.DEPTH (GROUPS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	iae_emit #(
		.GROUPS (GROUPS),
		.DIGITS (DIGITS)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.sum        (sum),
		.done       (done),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.full_valid (full_valid),
		.full_stall (full_stall),
		.full_data  (full_data)
	);

	// Hold off input after the final word until emission completes.
	`IAE_ASSERT_NEXT(a_busy_after_last, abbr_valid && !abbr_stall && abbr_data.in_last, abbr_stall, "input not held off after last word")
	// Release input only once the final output word is loaded.
	`IAE_ASSERT_NOW(a_release_on_last, $fell(abbr_stall), full_valid && full_data.out_last, "input released before last output word")
	// A pending middle word means emission is still running.
	`IAE_ASSERT_NOW(a_mid_word_busy, full_valid && !full_data.out_last, abbr_stall, "middle output word while input is open")
	// Store writes happen only while collecting.
	`IAE_ASSERT_NOW(a_write_when_idle, ram_we, !ram_re && (sum.start == 1'b0), "store write during emission")

endmodule
